@@ hw/rtl/dfs_topological_sort_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the depth-first topological sort block
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DFS_TOPOLOGICAL_SORT_TOP_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_TOP_MACROS_SVH

// Same-cycle implication.
`define DTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dts_pkg.sv @@
// ----------------------------------------------------------------------------
// dts_pkg
// Codes and shared types of the depth-first topological sort block.
// ----------------------------------------------------------------------------
package dts_pkg;

  // Width of the vertex fields and of the vertex count register.
  localparam int VTX_W = 7;

  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] ST_VERTEX = 2'd0;
  localparam logic [1:0] ST_CYCLE  = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // Control of the adjacency store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } adj_ctl_t;

endpackage

@@ hw/rtl/dts_ram.sv @@
// ----------------------------------------------------------------------------
// dts_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/dts_adj_store.sv @@
// ----------------------------------------------------------------------------
// dts_adj_store
// Adjacency matrix rows in a RAM, with one valid bit per row so that a clear
// only has to reset the valid bits. A row that is not valid reads as all zero.
// ----------------------------------------------------------------------------
module dts_adj_store
  import dts_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  adj_ctl_t                      ctl,
  input  logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] rd_addr,
  input  logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] wr_addr,
  input  logic [MAX_VERTICES-1:0]       wr_row,
  output logic [MAX_VERTICES-1:0]       rd_row
);

  logic [MAX_VERTICES-1:0] row_valid_r;
  logic                    rd_valid_r;
  logic [MAX_VERTICES-1:0] ram_q;

  dts_ram #(
    .WIDTH(MAX_VERTICES),
    .DEPTH(MAX_VERTICES)
  ) u_rows (
    .clk    (clk),
    .wr_en  (ctl.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_row),
    .rd_en  (ctl.rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (ctl.clr) begin
        row_valid_r <= '0;
      end else if (ctl.wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= row_valid_r[rd_addr];
      end
    end
  end

  assign rd_row = rd_valid_r ? ram_q : '0;

endmodule

@@ hw/rtl/dfs_topological_sort_top.sv @@
// ----------------------------------------------------------------------------
// dfs_topological_sort_top
// Depth-first topological sort over a bit adjacency matrix held in RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Handshake
//  --------  --------------------------------------  ---------------------------
//  input     in_kind, in_edge_from, in_edge_to       start high, busy low
//  result    out_status, out_vertex, out_last        out_valid, one cycle, no stall
//  config    cfg_data (vertex_count)                 cfg_valid and cfg_ready
//
// A clear word or an unused kind is handled in S_IDLE alone. A good edge
// reads its row from the adjacency RAM in S_IDLE and writes it back with the
// new bit in S_EDGE_WR. A bad edge or an empty run gives its result in the
// cycle after acceptance. In a run the neighbor scan tests one bit of the
// current row per cycle, and the finish order is then read back out of the
// stack RAM; a cycle result ends the run early.
// Reset is synchronous and active low; the row valid bits make it, and a
// clear, take effect at once. The receiver cannot stall, so results are only
// strobed out and busy alone paces the sender.
//
// The walk stack and the finish order share one RAM: the stack grows up from
// entry zero, the finish list grows down from the last entry. The vertex on
// top of the stack is kept in registers, so the two regions never meet.
// ----------------------------------------------------------------------------
`include "dfs_topological_sort_top_macros.svh"

module dfs_topological_sort_top
  import dts_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input words.
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_kind,
  input  logic [VTX_W-1:0] in_edge_from,
  input  logic [VTX_W-1:0] in_edge_to,
  // Result words.
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [VTX_W-1:0] out_vertex,
  output logic             out_last,
  // Configuration word: the vertex count.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VTX_W-1:0] cfg_data
);

  // Vertex index width, and width of a count that can hold MAX_VERTICES.
  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int SW = IW + NW;
  localparam int AW = NW + 1;
  localparam logic [NW-1:0]    MAXN = NW'(MAX_VERTICES);
  localparam logic [VTX_W-1:0] MAXV = VTX_W'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] ONE_BIT = MAX_VERTICES'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_WR,
    S_OUTER,
    S_SCAN,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t state_r;

  logic [VTX_W-1:0]        vcount_r;
  logic [NW-1:0]           n_r;
  logic [IW-1:0]           edge_addr_r;
  logic [IW-1:0]           edge_to_r;
  logic [MAX_VERTICES-1:0] visited_r;
  logic [MAX_VERTICES-1:0] onstack_r;
  logic [IW-1:0]           cur_v_r;
  logic [NW-1:0]           cur_j_r;
  logic [NW-1:0]           depth_r;
  logic [NW-1:0]           fin_r;
  logic [NW-1:0]           outer_r;
  logic [NW-1:0]           ptr_r;
  logic                    emit_q_r;
  logic                    emit_last_q_r;
  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic [VTX_W-1:0]        out_vertex_r;
  logic                    out_last_r;

  logic                    accept;
  logic [VTX_W-1:0]        n_eff;
  logic                    edge_ok;
  logic [VTX_W-1:0]        from_m1;
  logic [VTX_W-1:0]        to_m1;
  logic [IW-1:0]           j_idx;
  logic [IW-1:0]           outer_idx;
  logic                    scan_end;
  logic                    scan_hit;
  logic                    scan_cycle;
  logic                    scan_push;
  logic [NW-1:0]           fin_slot;
  logic [NW-1:0]           depth_m1;

  adj_ctl_t                adj_ctl;
  logic [IW-1:0]           adj_rd_addr;
  logic [MAX_VERTICES-1:0] adj_row;
  logic [MAX_VERTICES-1:0] adj_wr_row;

  logic                    st_wr_en;
  logic [IW-1:0]           st_wr_addr;
  logic [SW-1:0]           st_wr_data;
  logic                    st_rd_en;
  logic [IW-1:0]           st_rd_addr;
  logic [SW-1:0]           st_rd_data;
  logic [IW-1:0]           st_rd_v;
  logic [NW-1:0]           st_rd_j;

  assign busy      = (state_r != S_IDLE) || emit_q_r;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // A vertex count above the matrix size is used as the matrix size.
  assign n_eff   = (vcount_r > MAXV) ? MAXV : vcount_r;
  assign from_m1 = in_edge_from - VTX_W'(1);
  assign to_m1   = in_edge_to - VTX_W'(1);
  assign edge_ok = (in_edge_from != '0) && (in_edge_from <= n_eff) &&
                   (in_edge_to != '0) && (in_edge_to <= n_eff);

  // Neighbor scan of the row of the vertex on top of the stack. A set bit to a
  // vertex still on the walk is a back edge (a self-loop included).
  assign j_idx      = cur_j_r[IW-1:0];
  assign outer_idx  = outer_r[IW-1:0];
  assign scan_end   = (cur_j_r == n_r);
  assign scan_hit   = !scan_end && adj_row[j_idx];
  assign scan_cycle = scan_hit && onstack_r[j_idx];
  assign scan_push  = scan_hit && !visited_r[j_idx];

  assign fin_slot = MAXN - NW'(1) - fin_r;
  assign depth_m1 = depth_r - NW'(1);

  assign st_rd_v = st_rd_data[SW-1:NW];
  assign st_rd_j = st_rd_data[NW-1:0];

  always_comb begin
    adj_ctl     = '0;
    adj_rd_addr = cur_v_r;
    adj_wr_row  = adj_row | (ONE_BIT << edge_to_r);
    st_wr_en    = 1'b0;
    st_wr_addr  = depth_r[IW-1:0];
    st_wr_data  = {cur_v_r, cur_j_r + NW'(1)};
    st_rd_en    = 1'b0;
    st_rd_addr  = depth_m1[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        adj_rd_addr = from_m1[IW-1:0];
        if (accept && in_kind == KIND_EDGE && edge_ok) begin
          adj_ctl.rd_en = 1'b1;
        end
        if (accept && in_kind == KIND_CLEAR) begin
          adj_ctl.clr = 1'b1;
        end
      end
      S_EDGE_WR: begin
        adj_ctl.wr_en = 1'b1;
      end
      S_OUTER: begin
        adj_rd_addr = outer_idx;
        if (outer_r != n_r && !visited_r[outer_idx]) begin
          adj_ctl.rd_en = 1'b1;
        end
      end
      S_SCAN: begin
        adj_rd_addr = j_idx;
        if (scan_end) begin
          // The finished vertex goes to the finish list at the top of the RAM.
          st_wr_en   = 1'b1;
          st_wr_addr = fin_slot[IW-1:0];
          st_wr_data = {cur_v_r, NW'(0)};
          st_rd_en   = (depth_r != '0);
        end else if (scan_push) begin
          st_wr_en      = 1'b1;
          adj_ctl.rd_en = 1'b1;
        end
      end
      S_LOAD: begin
        adj_rd_addr   = st_rd_v;
        adj_ctl.rd_en = 1'b1;
      end
      S_EMIT: begin
        st_rd_en   = 1'b1;
        st_rd_addr = ptr_r[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  dts_adj_store #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_adj (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (adj_ctl),
    .rd_addr(adj_rd_addr),
    .wr_addr(edge_addr_r),
    .wr_row (adj_wr_row),
    .rd_row (adj_row)
  );

  dts_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_VERTICES)
  ) u_stack (
    .clk    (clk),
    .wr_en  (st_wr_en),
    .wr_addr(st_wr_addr),
    .wr_data(st_wr_data),
    .rd_en  (st_rd_en),
    .rd_addr(st_rd_addr),
    .rd_data(st_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      depth_r     <= '0;
      fin_r       <= '0;
      emit_q_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      emit_q_r    <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end

      // A word read from the finish list in the previous cycle leaves as a result.
      if (emit_q_r) begin
        out_valid_r  <= 1'b1;
        out_status_r <= ST_VERTEX;
        out_vertex_r <= VTX_W'(st_rd_v) + VTX_W'(1);
        out_last_r   <= emit_last_q_r;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_kind)
              KIND_EDGE: begin
                if (edge_ok) begin
                  edge_addr_r <= from_m1[IW-1:0];
                  edge_to_r   <= to_m1[IW-1:0];
                  state_r     <= S_EDGE_WR;
                end else begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_BAD;
                  out_vertex_r <= '0;
                  out_last_r   <= 1'b1;
                end
              end
              KIND_RUN: begin
                if (n_eff == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_EMPTY;
                  out_vertex_r <= '0;
                  out_last_r   <= 1'b1;
                end else begin
                  n_r       <= n_eff[NW-1:0];
                  visited_r <= '0;
                  onstack_r <= '0;
                  depth_r   <= '0;
                  fin_r     <= '0;
                  outer_r   <= '0;
                  state_r   <= S_OUTER;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_EDGE_WR: begin
          state_r <= S_IDLE;
        end
        S_OUTER: begin
          if (outer_r == n_r) begin
            ptr_r   <= MAXN - fin_r;
            state_r <= S_EMIT;
          end else begin
            outer_r <= outer_r + NW'(1);
            if (!visited_r[outer_idx]) begin
              visited_r[outer_idx] <= 1'b1;
              onstack_r[outer_idx] <= 1'b1;
              cur_v_r              <= outer_idx;
              cur_j_r              <= '0;
              state_r              <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            onstack_r[cur_v_r] <= 1'b0;
            fin_r              <= fin_r + NW'(1);
            if (depth_r == '0) begin
              state_r <= S_OUTER;
            end else begin
              depth_r <= depth_m1;
              state_r <= S_LOAD;
            end
          end else if (scan_cycle) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_CYCLE;
            out_vertex_r <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else if (scan_push) begin
            visited_r[j_idx] <= 1'b1;
            onstack_r[j_idx] <= 1'b1;
            depth_r          <= depth_r + NW'(1);
            cur_v_r          <= j_idx;
            cur_j_r          <= '0;
          end else begin
            cur_j_r <= cur_j_r + NW'(1);
          end
        end
        S_LOAD: begin
          cur_v_r <= st_rd_v;
          cur_j_r <= st_rd_j;
          state_r <= S_SCAN;
        end
        S_EMIT: begin
          emit_q_r      <= 1'b1;
          emit_last_q_r <= (ptr_r == MAXN - NW'(1));
          ptr_r         <= ptr_r + NW'(1);
          if (ptr_r == MAXN - NW'(1)) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_vertex = out_vertex_r;
  assign out_last   = out_last_r;

  // The stack below the top, the top itself and the finish list fit in n slots.
  `DTS_ASSERT_IMP(a_stack_room, state_r == S_SCAN,
    (AW'(depth_r) + AW'(fin_r)) < AW'(n_r), "stack and finish list overlap")
  // The vertex being scanned is always marked as on the walk.
  `DTS_ASSERT_IMP(a_top_on_walk, state_r == S_SCAN, onstack_r[cur_v_r],
    "top of stack is not on the walk")
  // Every result other than a sorted vertex is the only one for its input word.
  `DTS_ASSERT_IMP(a_single_last, out_valid && (out_status != ST_VERTEX), out_last,
    "single result without last")
  // A run on an empty graph answers in the next cycle.
  `DTS_ASSERT_NXT(a_empty_run, accept && (in_kind == KIND_RUN) && (n_eff == '0),
    out_valid && (out_status == ST_EMPTY), "empty run gave no empty result")

endmodule

@@ tb/dfs_topological_sort_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_topological_sort_top_tb
// Self-checking bench for the depth-first topological sort block. A short
// directed table reaches the corner cases first. Random graph phases follow,
// mostly acyclic graphs with some cycles, bad edges and noise. Every result
// word is checked against a pinned status or a predictor beside the block.
// ----------------------------------------------------------------------------
module dfs_topological_sort_top_tb
  import dts_pkg::*;
();

  localparam int MAX_V = 64;
  // Kind 3 has no meaning to the block and must be dropped silently.
  localparam logic [1:0] KIND_SPARE = 2'd3;
  // Word count of the whole run; the directed table supplies the first ones.
  localparam int TOTAL_WORDS = 400;
  // Quiet cycles after the last expected word before the count register
  // changes or the run ends. A good edge writes its row after it is taken.
  localparam int DRAIN_CYCLES = 8;
  // A walk over 64 vertices ends well within this limit.
  localparam int END_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]       status;
    logic [VTX_W-1:0] vertex;
    logic             last;
  } sort_word_t;

  typedef enum logic {ROW_WORD, ROW_COUNT} row_op_t;

  typedef struct packed {
    row_op_t          op;
    logic [1:0]       kind;
    logic [VTX_W-1:0] src_v;
    logic [VTX_W-1:0] dst_v;
    logic [VTX_W-1:0] count;
    logic             pinned;
    logic [1:0]       pin_status;
  } probe_row_t;

  // Directed table. A row either writes the vertex count or sends one input
  // word. Pinned rows carry their expected status (vertex 0, last 1); all
  // other rows are checked against the predictor.
  localparam int PROBE_ROWS = 31;
  localparam probe_row_t PROBE_TABLE [PROBE_ROWS] = '{
    // Count is zero after reset: a run sees an empty graph and every edge
    // is out of range. The spare kind is ignored.
    '{ROW_WORD,  KIND_RUN,   7'd0,   7'd0,   7'd0,   1'b1, ST_EMPTY},
    '{ROW_WORD,  KIND_EDGE,  7'd1,   7'd1,   7'd0,   1'b1, ST_BAD},
    '{ROW_WORD,  KIND_SPARE, 7'd127, 7'd127, 7'd0,   1'b0, ST_VERTEX},
    // A count above the maximum acts as the maximum.
    '{ROW_COUNT, KIND_EDGE,  7'd0,   7'd0,   7'd127, 1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_EDGE,  7'd64,  7'd1,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_EDGE,  7'd1,   7'd2,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_EDGE,  7'd0,   7'd5,   7'd0,   1'b1, ST_BAD},
    '{ROW_WORD,  KIND_EDGE,  7'd5,   7'd65,  7'd0,   1'b1, ST_BAD},
    '{ROW_WORD,  KIND_EDGE,  7'd127, 7'd127, 7'd0,   1'b1, ST_BAD},
    '{ROW_WORD,  KIND_RUN,   7'd0,   7'd0,   7'd0,   1'b0, ST_VERTEX},
    // Closing the loop 64 -> 1 -> 2 -> 64 turns the next run into a cycle.
    '{ROW_WORD,  KIND_EDGE,  7'd2,   7'd64,  7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_RUN,   7'd0,   7'd0,   7'd0,   1'b1, ST_CYCLE},
    '{ROW_WORD,  KIND_CLEAR, 7'd0,   7'd0,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_RUN,   7'd0,   7'd0,   7'd0,   1'b0, ST_VERTEX},
    // Edges that go stale once the count shrinks to two.
    '{ROW_COUNT, KIND_EDGE,  7'd0,   7'd0,   7'd64,  1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_EDGE,  7'd1,   7'd40,  7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_EDGE,  7'd40,  7'd2,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_EDGE,  7'd3,   7'd3,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_COUNT, KIND_EDGE,  7'd0,   7'd0,   7'd2,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_RUN,   7'd0,   7'd0,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_EDGE,  7'd2,   7'd1,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_RUN,   7'd0,   7'd0,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_EDGE,  7'd1,   7'd2,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_RUN,   7'd0,   7'd0,   7'd0,   1'b1, ST_CYCLE},
    // A single vertex with a self-loop, then without it.
    '{ROW_COUNT, KIND_EDGE,  7'd0,   7'd0,   7'd1,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_EDGE,  7'd1,   7'd1,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_RUN,   7'd0,   7'd0,   7'd0,   1'b1, ST_CYCLE},
    '{ROW_WORD,  KIND_CLEAR, 7'd0,   7'd0,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_RUN,   7'd0,   7'd0,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_COUNT, KIND_EDGE,  7'd0,   7'd0,   7'd0,   1'b0, ST_VERTEX},
    '{ROW_WORD,  KIND_EDGE,  7'd0,   7'd0,   7'd0,   1'b1, ST_BAD}
  };

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_kind;
  logic [VTX_W-1:0] in_edge_from;
  logic [VTX_W-1:0] in_edge_to;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [VTX_W-1:0] out_vertex;
  logic             out_last;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [VTX_W-1:0] cfg_data;

  // Predictor state: its own copy of the adjacency matrix and the count.
  logic [MAX_V-1:0] adj_rows [MAX_V];
  logic [VTX_W-1:0] vertex_limit;

  // Words the predictor produced for the latest input word, and the words
  // still owed by the block, oldest first.
  sort_word_t       fresh_words [$];
  sort_word_t       owed_words [$];
  sort_word_t       oldest;

  int               failures;
  int               words_sent;
  // Percent chance of a sender gap before a word; zero in the final stretch.
  int               gap_odds;

  dfs_topological_sort_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_edge_from (in_edge_from),
    .in_edge_to   (in_edge_to),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_vertex   (out_vertex),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Works out what one accepted input word produces and updates the
  // predictor's graph. The walk keeps an explicit stack of vertices and the
  // next neighbor to scan for each; vertices are marked 1 while on the stack
  // and 2 once finished, so reaching a vertex marked 1 means a cycle.
  task automatic predict_word(input logic [1:0] kind, input logic [VTX_W-1:0] src,
                              input logic [VTX_W-1:0] dst);
    int         n;
    int         depth;
    int         done;
    int         v;
    int         j;
    bit         pushed;
    bit         looped;
    logic [1:0] mark [MAX_V];
    int         stack_v [MAX_V];
    int         stack_next [MAX_V];
    int         finished [MAX_V];
    fresh_words.delete();
    n = (vertex_limit > MAX_V) ? MAX_V : int'(vertex_limit);
    case (kind)
      KIND_EDGE: begin
        if (src < 1 || src > n || dst < 1 || dst > n)
          fresh_words.push_back('{status: ST_BAD, vertex: '0, last: 1'b1});
        else
          adj_rows[src - 1][dst - 1] = 1'b1;
      end
      KIND_CLEAR: begin
        foreach (adj_rows[r]) adj_rows[r] = '0;
      end
      KIND_RUN: begin
        if (n == 0) begin
          fresh_words.push_back('{status: ST_EMPTY, vertex: '0, last: 1'b1});
        end else begin
          foreach (mark[m]) mark[m] = 2'd0;
          done = 0;
          looped = 1'b0;
          for (int s = 0; s < n && !looped; s++) begin
            if (mark[s] == 2'd0) begin
              mark[s] = 2'd1;
              stack_v[0] = s;
              stack_next[0] = 0;
              depth = 1;
              while (depth > 0 && !looped) begin
                v = stack_v[depth - 1];
                j = stack_next[depth - 1];
                pushed = 1'b0;
                while (j < n && !pushed && !looped) begin
                  if (adj_rows[v][j]) begin
                    stack_next[depth - 1] = j + 1;
                    if (mark[j] == 2'd1) begin
                      looped = 1'b1;
                    end else if (mark[j] == 2'd0) begin
                      mark[j] = 2'd1;
                      stack_v[depth] = j;
                      stack_next[depth] = 0;
                      depth++;
                      pushed = 1'b1;
                    end
                  end
                  j++;
                end
                if (!pushed && !looped) begin
                  mark[v] = 2'd2;
                  finished[done] = v;
                  done++;
                  depth--;
                end
              end
            end
          end
          if (looped) begin
            fresh_words.push_back('{status: ST_CYCLE, vertex: '0, last: 1'b1});
          end else begin
            // Reverse finish order is the topological order.
            for (int k = 0; k < done; k++)
              fresh_words.push_back('{status: ST_VERTEX,
                                      vertex: VTX_W'(finished[done - 1 - k] + 1),
                                      last: (k == done - 1)});
          end
        end
      end
      default: ;
    endcase
  endtask

  // Sends one input word and records what it owes. A pinned word owes its
  // typed-in status instead of the predicted one; the predictor still runs
  // so that its graph follows the block's.
  task automatic send_word(input logic [1:0] kind, input logic [VTX_W-1:0] src,
                           input logic [VTX_W-1:0] dst, input logic pinned,
                           input logic [1:0] pin_status);
    if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_kind      <= kind;
    in_edge_from <= src;
    in_edge_to   <= dst;
    start        <= 1'b1;
    // The word is taken at the first edge that sees busy low.
    do @(posedge clk); while (busy);
    predict_word(kind, src, dst);
    if (pinned)
      owed_words.push_back('{status: pin_status, vertex: '0, last: 1'b1});
    else
      while (fresh_words.size() != 0) owed_words.push_back(fresh_words.pop_front());
    if (kind != KIND_SPARE) words_sent++;
  endtask

  // The count may only change while the block is idle: every owed word has
  // come back and a good edge has had time to write its row.
  task automatic write_vertex_count(input logic [VTX_W-1:0] value);
    start <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vertex_limit = value;
  endtask

  // Result checker. The block cannot be held off, so every strobed word is
  // compared at once with the oldest owed word.
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (owed_words.size() == 0) begin
        $error("unexpected result word: status %0d vertex %0d last %0d",
               out_status, out_vertex, out_last);
        failures++;
      end else begin
        oldest = owed_words.pop_front();
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_status);
          failures++;
        end
        if (out_vertex !== oldest.vertex) begin
          $error("vertex: expected %0d, got %0d", oldest.vertex, out_vertex);
          failures++;
        end
        if (out_last !== oldest.last) begin
          $error("last: expected %0d, got %0d", oldest.last, out_last);
          failures++;
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random graph phases.
  initial begin
    int               n;
    int               pick;
    int               edge_slots;
    int               a;
    int               b;
    int               tmp;
    int               waited;
    bit               dag_only;
    logic [VTX_W-1:0] count_value;
    int               order [MAX_V];

    failures     = 0;
    words_sent   = 0;
    gap_odds     = 20;
    vertex_limit = '0;
    foreach (adj_rows[r]) adj_rows[r] = '0;

    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_kind      <= KIND_EDGE;
    in_edge_from <= '0;
    in_edge_to   <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PROBE_TABLE[i]) begin
      if (PROBE_TABLE[i].op == ROW_COUNT)
        write_vertex_count(PROBE_TABLE[i].count);
      else
        send_word(PROBE_TABLE[i].kind, PROBE_TABLE[i].src_v, PROBE_TABLE[i].dst_v,
                  PROBE_TABLE[i].pinned, PROBE_TABLE[i].pin_status);
    end

    // Each random phase picks a count, clears the graph, and then does one
    // to three rounds of edges followed by a run. Most counts are small so
    // that walks stay short; the extremes still come up now and then.
    while (words_sent < TOTAL_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       count_value = 7'd0;
      else if (pick < 10) count_value = 7'd1;
      else if (pick < 14) count_value = 7'd64;
      else if (pick < 18) count_value = VTX_W'($urandom_range(65, 127));
      else                count_value = VTX_W'($urandom_range(2, 10));
      write_vertex_count(count_value);
      n = (count_value > MAX_V) ? MAX_V : int'(count_value);

      // The final quarter of the run goes without sender gaps.
      if (words_sent >= TOTAL_WORDS * 3 / 4) begin
        gap_odds = 0;
      end else begin
        pick = $urandom_range(0, 2);
        gap_odds = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
      end

      // Most phases build an acyclic graph so that the full order comes out;
      // the rest mix in arbitrary edges, which often close a cycle.
      dag_only = ($urandom_range(0, 99) < 65);
      for (int i = 0; i < n; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        a = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[a];
        order[a] = tmp;
      end

      send_word(KIND_CLEAR, VTX_W'($urandom), VTX_W'($urandom), 1'b0, ST_VERTEX);
      repeat ($urandom_range(1, 3)) begin
        edge_slots = (n == 0) ? 3 : $urandom_range(0, (n < 12) ? 2 * n : 24);
        repeat (edge_slots) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) begin
            // A clear in the middle of a sequence.
            send_word(KIND_CLEAR, VTX_W'($urandom), VTX_W'($urandom), 1'b0, ST_VERTEX);
          end else if (pick < 8) begin
            send_word(KIND_SPARE, VTX_W'($urandom), VTX_W'($urandom), 1'b0, ST_VERTEX);
          end else if (pick < 16 || n == 0) begin
            // Any endpoints at all, mostly out of range.
            send_word(KIND_EDGE, VTX_W'($urandom), VTX_W'($urandom), 1'b0, ST_VERTEX);
          end else if (!dag_only || n < 2) begin
            send_word(KIND_EDGE, VTX_W'($urandom_range(1, n)), VTX_W'($urandom_range(1, n)),
                      1'b0, ST_VERTEX);
          end else begin
            // Edges only run forward in the shuffled order, so no cycle.
            a = $urandom_range(0, n - 2);
            b = $urandom_range(a + 1, n - 1);
            send_word(KIND_EDGE, VTX_W'(order[a] + 1), VTX_W'(order[b] + 1),
                      1'b0, ST_VERTEX);
          end
        end
        send_word(KIND_RUN, VTX_W'($urandom), VTX_W'($urandom), 1'b0, ST_VERTEX);
      end
    end
    start <= 1'b0;

    // Let the last walk finish and its words drain, then a short quiet spell
    // to catch anything extra.
    waited = 0;
    while (owed_words.size() != 0 && waited < END_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_words.size() != 0) begin
      $error("%0d result words never arrived", owed_words.size());
      failures++;
    end

    if (failures == 0) begin
      $display("dfs_topological_sort_top_tb OK");
    end else begin
      $display("dfs_topological_sort_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: a healthy run ends far sooner than this.
  initial begin
    #50000000;
    $display("dfs_topological_sort_top_tb NOT OK");
    $finish;
  end

endmodule
